FILE: hdl/gtsp_pkg.sv
// Shared types, constants and the move table for the grid path search.
`timescale 1ns / 1ps
`default_nettype none
package gtsp_pkg;

  // Default sizes
  localparam int DEF_MAX_COLS  = 32;
  localparam int DEF_MAX_ROWS  = 64;
  localparam int DEF_COST_BITS = 16;

  // Configuration register fields and reset values
  localparam int GW_BITS = 6;
  localparam int GH_BITS = 7;
  localparam logic [GW_BITS-1:0] GW_RESET = 6'd32;
  localparam logic [GH_BITS-1:0] GH_RESET = 7'd64;

  // Register indexes
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Number of moves per state
  localparam int NUM_MOVES = 9;

  // Cell kinds
  typedef enum logic [1:0] {
    KIND_ORDINARY = 2'd0,
    KIND_START    = 2'd1,
    KIND_TARGET   = 2'd2,
    KIND_BLOCKED  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] cell_kind;
    logic [3:0] cell_cost;
    logic       last_cell;
  } in_item_t;

  typedef struct packed {
    logic [15:0] min_cost;
    logic        reachable;
  } out_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] cost;
  } cell_t;

  // Row offset of move k, two's complement
  function automatic logic [2:0] move_di(input logic [3:0] k);
    logic [2:0] d;
    case (k)
      4'd0:    d = 3'b110;
      4'd1:    d = 3'b111;
      4'd2:    d = 3'b111;
      4'd3:    d = 3'b000;
      4'd4:    d = 3'b000;
      4'd5:    d = 3'b000;
      4'd6:    d = 3'b001;
      4'd7:    d = 3'b001;
      4'd8:    d = 3'b010;
      default: d = 3'b000;
    endcase
    return d;
  endfunction

  // Column step of move k
  function automatic logic [1:0] move_dj(input logic [3:0] k);
    logic [1:0] d;
    case (k)
      4'd0:    d = 2'd1;
      4'd1:    d = 2'd1;
      4'd2:    d = 2'd2;
      4'd3:    d = 2'd1;
      4'd4:    d = 2'd2;
      4'd5:    d = 2'd3;
      4'd6:    d = 2'd1;
      4'd7:    d = 2'd2;
      4'd8:    d = 2'd1;
      default: d = 2'd1;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/grid_two_phase_shortest_path.sv
// Top level: cell loading, best-cost search sequencer and configuration port.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_valid / in_ready  | in_data  (cell_kind, cell_cost, last_cell)
//  out_    | out | out_valid / out_ready| out_data (min_cost, reachable)
//  cfg     | in  | psel/penable/pready  | paddr, pwdata, prdata (grid_width, grid_height)
//
// Cells load one per cycle into the cell memory while in_ready is high. The cell flagged last
// starts a search: a clearing pass over all 2^(log2(rows)+log2(cols)+1) best-cost entries
// (4096 by default), a seed scan of the cells, then each dequeued state tries every move
// through the shared neighbor unit, and a final scan of the cells.
// in_ready is low during the search; the result register holds a result until taken
// while the next grid loads. Reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none
module grid_two_phase_shortest_path #(
  parameter int MAX_COLS  = gtsp_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS  = gtsp_pkg::DEF_MAX_ROWS,
  parameter int COST_BITS = gtsp_pkg::DEF_COST_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gtsp_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output gtsp_pkg::out_item_t     out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import gtsp_pkg::*;

  localparam int XW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int CAW   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LPW   = $clog2(CELLS + 1);
  localparam int SAW   = YW + XW + 1;
  localparam int SD    = 1 << SAW;
  localparam int BW    = COST_BITS + 1;
  localparam logic [COST_BITS-1:0] CMAX = {COST_BITS{1'b1}};

  typedef enum logic [3:0] {
    S_LOAD, S_CLR, S_SD_RD, S_SD_CK, S_SD_S1, S_POP, S_POP_W, S_POP_C,
    S_NB, S_NB_CK, S_FN_RD, S_FN_A, S_FN_B, S_DONE
  } state_t;

  // Memories
  cell_t           cell_mem [CELLS];
  logic [BW-1:0]   best_mem [SD];
  logic [SAW-1:0]  fifo_mem [SD];

  state_t          state_r, state_nxt;
  logic [LPW-1:0]  ld_pos_r, ld_pos_nxt;
  logic [CW-1:0]   w_r, w_nxt;
  logic [RW-1:0]   h_r, h_nxt;
  logic [SAW-1:0]  clr_r, clr_nxt;
  logic [XW-1:0]   x_r, x_nxt;
  logic [YW-1:0]   y_r, y_nxt;
  logic [CAW-1:0]  lin_r, lin_nxt;
  logic [SAW-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [SAW:0]    cnt_r, cnt_nxt;
  logic [SAW-1:0]  u_r, u_nxt;
  logic [COST_BITS-1:0] cur_r, cur_nxt, min_r, min_nxt;
  logic [3:0]      k_r, k_nxt;
  logic [XW-1:0]   nx_r, nx_nxt;
  logic [YW-1:0]   ny_r, ny_nxt;
  logic            tgt_r, tgt_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;
  logic [GW_BITS-1:0] cfg_w_r;
  logic [GH_BITS-1:0] cfg_h_r;

  // Memory ports
  logic            cell_we;
  logic [CAW-1:0]  cell_wa, cell_ra;
  cell_t           cell_wd, cell_q;
  logic            best_we;
  logic [SAW-1:0]  best_wa, best_ra;
  logic [BW-1:0]   best_wd, best_q;
  logic            fifo_we;
  logic [SAW-1:0]  fifo_ra;
  logic [SAW-1:0]  fifo_wd, fifo_q;

  // Neighbor unit
  logic            nb_inb;
  logic [XW-1:0]   nb_nx;
  logic [YW-1:0]   nb_ny;
  logic [CAW-1:0]  nb_caddr;

  logic [CW-1:0]   w_clamp;
  logic [RW-1:0]   h_clamp;
  logic            scan_end;
  logic [XW-1:0]   adv_x;
  logic [YW-1:0]   adv_y;
  logic [COST_BITS:0] sum_w;
  logic [COST_BITS-1:0] sum;
  logic [31:0]     min_ext;

  gtsp_nbr #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_nbr (
    .x    (u_r[XW:1]),
    .y    (u_r[SAW-1 -: YW]),
    .side (u_r[0]),
    .k    (k_r),
    .w    (w_r),
    .h    (h_r),
    .inb  (nb_inb),
    .nx   (nb_nx),
    .ny   (nb_ny),
    .caddr(nb_caddr)
  );

  // APB configuration port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_GRID_WIDTH:  prdata = 32'(cfg_w_r);
      REG_GRID_HEIGHT: prdata = 32'(cfg_h_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= GW_RESET;
      cfg_h_r <= GH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_GRID_WIDTH:  cfg_w_r <= pwdata[GW_BITS-1:0];
        REG_GRID_HEIGHT: cfg_h_r <= pwdata[GH_BITS-1:0];
        default:         ;
      endcase
    end
  end

  // Clamp grid size into the supported range
  always_comb begin
    if (cfg_w_r == '0) begin
      w_clamp = CW'(1);
    end else if (32'(cfg_w_r) > MAX_COLS) begin
      w_clamp = CW'(MAX_COLS);
    end else begin
      w_clamp = CW'(cfg_w_r);
    end
    if (cfg_h_r == '0) begin
      h_clamp = RW'(1);
    end else if (32'(cfg_h_r) > MAX_ROWS) begin
      h_clamp = RW'(MAX_ROWS);
    end else begin
      h_clamp = RW'(cfg_h_r);
    end
  end

  // Row-major scan position helpers
  always_comb begin
    scan_end = ((CW+1)'(x_r) + (CW+1)'(1) == (CW+1)'(w_r)) &&
               ((RW+1)'(y_r) + (RW+1)'(1) == (RW+1)'(h_r));
    if ((CW+1)'(x_r) + (CW+1)'(1) == (CW+1)'(w_r)) begin
      adv_x = '0;
      adv_y = y_r + YW'(1);
    end else begin
      adv_x = x_r + XW'(1);
      adv_y = y_r;
    end
  end

  // Saturating relax sum
  always_comb begin
    sum_w = {1'b0, cur_r} +
            ((cell_q.kind == KIND_ORDINARY) ? (COST_BITS+1)'(cell_q.cost) : '0);
    sum = sum_w[COST_BITS] ? CMAX : sum_w[COST_BITS-1:0];
    min_ext = 32'(min_r);
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    ld_pos_nxt    = ld_pos_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    clr_nxt       = clr_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    lin_nxt       = lin_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    u_nxt         = u_r;
    cur_nxt       = cur_r;
    min_nxt       = min_r;
    k_nxt         = k_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    tgt_nxt       = tgt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cell_we = 1'b0;
    cell_wa = ld_pos_r[CAW-1:0];
    cell_wd = cell_t'({in_data.cell_kind, in_data.cell_cost});
    cell_ra = lin_r;
    best_we = 1'b0;
    best_wa = clr_r;
    best_wd = {1'b0, CMAX};
    best_ra = {y_r, x_r, 1'b0};
    fifo_we = 1'b0;
    fifo_wd = {y_r, x_r, 1'b0};
    fifo_ra = head_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (32'(ld_pos_r) < CELLS) begin
            cell_we    = 1'b1;
            ld_pos_nxt = ld_pos_r + LPW'(1);
          end
          if (in_data.last_cell) begin
            ld_pos_nxt = '0;
            w_nxt      = w_clamp;
            h_nxt      = h_clamp;
            clr_nxt    = '0;
            state_nxt  = S_CLR;
          end
        end
      end
      S_CLR: begin
        best_we = 1'b1;
        clr_nxt = clr_r + SAW'(1);
        if (clr_r == {SAW{1'b1}}) begin
          x_nxt     = '0;
          y_nxt     = '0;
          lin_nxt   = '0;
          head_nxt  = '0;
          tail_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_SD_RD;
        end
      end
      S_SD_RD: begin
        state_nxt = S_SD_CK;
      end
      S_SD_CK, S_SD_S1: begin
        if (state_r == S_SD_S1 || cell_q.kind == KIND_START) begin
          best_we  = 1'b1;
          best_wa  = {y_r, x_r, (state_r == S_SD_S1)};
          best_wd  = {1'b1, {COST_BITS{1'b0}}};
          fifo_we  = 1'b1;
          fifo_wd  = {y_r, x_r, (state_r == S_SD_S1)};
          tail_nxt = tail_r + SAW'(1);
          cnt_nxt  = cnt_r + (SAW+1)'(1);
        end
        if (state_r == S_SD_CK && cell_q.kind == KIND_START) begin
          state_nxt = S_SD_S1;
        end else begin
          x_nxt     = adv_x;
          y_nxt     = adv_y;
          lin_nxt   = lin_r + CAW'(1);
          state_nxt = scan_end ? S_POP : S_SD_RD;
        end
      end
      S_POP: begin
        if (cnt_r == '0) begin
          x_nxt     = '0;
          y_nxt     = '0;
          lin_nxt   = '0;
          min_nxt   = CMAX;
          state_nxt = S_FN_RD;
        end else begin
          state_nxt = S_POP_W;
        end
      end
      S_POP_W: begin
        u_nxt     = fifo_q;
        head_nxt  = head_r + SAW'(1);
        cnt_nxt   = cnt_r - (SAW+1)'(1);
        best_ra   = fifo_q;
        state_nxt = S_POP_C;
      end
      S_POP_C: begin
        // Dequeued: clear its queued flag
        best_we   = 1'b1;
        best_wa   = u_r;
        best_wd   = {1'b0, best_q[COST_BITS-1:0]};
        cur_nxt   = best_q[COST_BITS-1:0];
        k_nxt     = '0;
        state_nxt = S_NB;
      end
      S_NB: begin
        cell_ra = nb_caddr;
        best_ra = {nb_ny, nb_nx, ~u_r[0]};
        nx_nxt  = nb_nx;
        ny_nxt  = nb_ny;
        if (nb_inb) begin
          state_nxt = S_NB_CK;
        end else if (k_r == 4'(NUM_MOVES - 1)) begin
          state_nxt = S_POP;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end
      S_NB_CK: begin
        // Relax one neighbor state
        if (cell_q.kind != KIND_BLOCKED && sum < best_q[COST_BITS-1:0]) begin
          best_we = 1'b1;
          best_wa = {ny_r, nx_r, ~u_r[0]};
          best_wd = {1'b1, sum};
          if (!best_q[COST_BITS]) begin
            fifo_we  = 1'b1;
            fifo_wd  = {ny_r, nx_r, ~u_r[0]};
            tail_nxt = tail_r + SAW'(1);
            cnt_nxt  = cnt_r + (SAW+1)'(1);
          end
        end
        if (k_r == 4'(NUM_MOVES - 1)) begin
          state_nxt = S_POP;
        end else begin
          k_nxt     = k_r + 4'd1;
          state_nxt = S_NB;
        end
      end
      S_FN_RD: begin
        state_nxt = S_FN_A;
      end
      S_FN_A: begin
        tgt_nxt = (cell_q.kind == KIND_TARGET);
        if (cell_q.kind == KIND_TARGET && best_q[COST_BITS-1:0] < min_r) begin
          min_nxt = best_q[COST_BITS-1:0];
        end
        best_ra   = {y_r, x_r, 1'b1};
        state_nxt = S_FN_B;
      end
      S_FN_B: begin
        if (tgt_r && best_q[COST_BITS-1:0] < min_r) begin
          min_nxt = best_q[COST_BITS-1:0];
        end
        x_nxt     = adv_x;
        y_nxt     = adv_y;
        lin_nxt   = lin_r + CAW'(1);
        state_nxt = scan_end ? S_DONE : S_FN_RD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (min_r != CMAX) begin
            out_data_nxt.reachable = 1'b1;
            out_data_nxt.min_cost  = (min_ext > 32'hFFFF) ? 16'hFFFF : min_ext[15:0];
          end else begin
            out_data_nxt.reachable = 1'b0;
            out_data_nxt.min_cost  = '0;
          end
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      ld_pos_r    <= '0;
      cnt_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ld_pos_r    <= ld_pos_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    clr_r      <= clr_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    lin_r      <= lin_nxt;
    u_r        <= u_nxt;
    cur_r      <= cur_nxt;
    min_r      <= min_nxt;
    k_r        <= k_nxt;
    nx_r       <= nx_nxt;
    ny_r       <= ny_nxt;
    tgt_r      <= tgt_nxt;
    out_data_r <= out_data_nxt;
  end

  // Cell memory
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_wa] <= cell_wd;
    end
    cell_q <= cell_mem[cell_ra];
  end

  // Best-cost memory: {queued, cost} per state
  always_ff @(posedge clk) begin
    if (best_we) begin
      best_mem[best_wa] <= best_wd;
    end
    best_q <= best_mem[best_ra];
  end

  // Work queue of states
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[tail_r] <= fifo_wd;
    end
    fifo_q <= fifo_mem[fifo_ra];
  end

endmodule
`default_nettype wire

FILE: hdl/gtsp_nbr.sv
// Neighbor generator: coordinates, bounds check and cell address of one move.
`timescale 1ns / 1ps
`default_nettype none
module gtsp_nbr #(
  parameter int MAX_COLS = gtsp_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gtsp_pkg::DEF_MAX_ROWS
) (
  input  wire logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0]     x,
  input  wire logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0]     y,
  input  wire logic                                                   side,
  input  wire logic [3:0]                                             k,
  input  wire logic [$clog2(MAX_COLS+1)-1:0]                          w,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]                          h,
  output logic                                                        inb,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0]          nx,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0]          ny,
  output logic [((MAX_COLS*MAX_ROWS > 1) ? $clog2(MAX_COLS*MAX_ROWS) : 1)-1:0] caddr
);
  import gtsp_pkg::*;

  localparam int XW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int YW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int CAW = (MAX_COLS * MAX_ROWS > 1) ? $clog2(MAX_COLS * MAX_ROWS) : 1;
  localparam int PW  = YW + CW + 1;

  logic [2:0]    di;
  logic [1:0]    dj;
  logic [XW+2:0] sx;
  logic [YW+2:0] sy;
  logic [PW-1:0] prod;

  // Column moves left on side 1, right on side 0; negative shows in the top bit
  always_comb begin
    di = move_di(k);
    dj = move_dj(k);
    if (side) begin
      sx = {3'b000, x} - {{(XW+1){1'b0}}, dj};
    end else begin
      sx = {3'b000, x} + {{(XW+1){1'b0}}, dj};
    end
    sy = {3'b000, y} + {{YW{di[2]}}, di};
    inb = !sx[XW+2] && ((XW+3)'(sx) < (XW+3)'(w)) &&
          !sy[YW+2] && ((YW+3)'(sy) < (YW+3)'(h));
    nx = sx[XW-1:0];
    ny = sy[YW-1:0];
    prod = PW'(ny) * PW'(w) + PW'(nx);
    caddr = prod[CAW-1:0];
  end

endmodule
`default_nettype wire

FILE: hdl/gtsp_chk.sv
// Port-level checker for the grid path search block and its bind.
`timescale 1ns / 1ps
`default_nettype none
module gtsp_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire gtsp_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire gtsp_pkg::out_item_t out_data
);
  import gtsp_pkg::*;

  // A last-cell transfer starts a search, so input stalls next cycle
  a_search_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_cell |=> !in_ready)
    else $error("input not stalled after last cell");

  // Unreachable result carries zero cost
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reachable |-> out_data.min_cost == 16'd0)
    else $error("unreachable result with nonzero cost");

  // Held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind grid_two_phase_shortest_path gtsp_chk u_gtsp_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire
